// ===== sv/cksm_pkg.sv =====
// ----------------------------------------------------------------------------
// cksm_pkg
// Shared codes and character constants for the ctrl-key escape sequence
// matcher: parser phase types and the fixed byte values of the sequences.
// ----------------------------------------------------------------------------
package cksm_pkg;

    typedef enum logic [6:0] {
        KP_PREFIX = 7'b0000001,
        KP_CODE0  = 7'b0000010,
        KP_CODE   = 7'b0000100,
        KP_MOD0   = 7'b0001000,
        KP_MOD    = 7'b0010000,
        KP_TAIL   = 7'b0100000,
        KP_FAIL   = 7'b1000000
    } csiu_phase_t;

    typedef enum logic [5:0] {
        MP_PREFIX = 6'b000001,
        MP_MOD0   = 6'b000010,
        MP_MOD    = 6'b000100,
        MP_KEY0   = 6'b001000,
        MP_KEY    = 6'b010000,
        MP_FAIL   = 6'b100000
    } mok_phase_t;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] ENTER_KEY   = 8'd13;
    localparam int         CTRL_BIT    = 2;
    localparam logic [4:0] LETTER_MAX  = 5'd25;
    localparam logic [2:0] COUNT_MAX   = 3'd7;
    localparam logic [2:0] MOK_PREFIX_LEN = 3'd5;

    // ESC [ 2 7 ;
    function automatic logic [7:0] mok_prefix_byte(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_ESC;
            3'd1:    ch = CH_LBRACKET;
            3'd2:    ch = 8'h32;
            3'd3:    ch = 8'h37;
            3'd4:    ch = CH_SEMI;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/ctrl_key_escape_sequence_matcher.sv =====
// ----------------------------------------------------------------------------
// ctrl_key_escape_sequence_matcher
// Parses the bytes of one terminal key event and reports Ctrl+letter and
// Ctrl+Enter on the last byte.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and every byte is parsed in the cycle it is
// accepted: the CSI-u and modifyOtherKeys parsers each update their decimal
// token with one multiply-by-ten and add. Only the byte flagged by tlast
// produces a request on the master side; it is registered in the cycle
// after acceptance, and the input keeps accepting while that register is
// empty or being taken. The target letter (0 = a .. 25 = z) is written by
// the user via cfg_wen/cfg_wdata, only while idle; this is not enforced.
module ctrl_key_escape_sequence_matcher #(
    parameter int VALUE_BITS = 31
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic [4:0] cfg_wdata,    // target_letter
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // in_byte
    input  logic       s_tlast,      // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata       // ctrl_letter_hit, ctrl_enter_hit, zero pad
);
    import cksm_pkg::*;

    localparam int WIDE_BITS = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    logic [4:0]            target_letter_reg;
    logic [2:0]            byte_count_reg, byte_count_next;
    csiu_phase_t           csiu_phase_reg, csiu_phase_next;
    logic [VALUE_BITS-1:0] csiu_code_reg, csiu_code_next;
    logic [VALUE_BITS-1:0] csiu_mod_reg, csiu_mod_next;
    mok_phase_t            mok_phase_reg, mok_phase_next;
    logic [VALUE_BITS-1:0] mok_mod_reg, mok_mod_next;
    logic [VALUE_BITS-1:0] mok_key_reg, mok_key_next;
    logic [3:0]            overflow_reg, overflow_next;
    logic                  m_tvalid_reg;
    logic [1:0]            hits_reg, hits_next;

    logic                  s_accept;
    logic                  is_digit;
    logic [7:0]            b;
    logic                  letter_ok;
    logic [VALUE_BITS-1:0] lower_val, upper_val;

    function automatic logic [VALUE_BITS:0] accumulate(
        input logic [VALUE_BITS-1:0] v,
        input logic [7:0]            ch
    );
        logic [WIDE_BITS-1:0] wide;
        logic [WIDE_BITS-1:0] ext;
        ext  = WIDE_BITS'(v);
        wide = (ext << 3) + (ext << 1) + WIDE_BITS'(ch - CH_ZERO);
        if (wide > WIDE_BITS'(VALUE_MAX)) begin
            return {1'b1, VALUE_MAX};
        end
        return {1'b0, wide[VALUE_BITS-1:0]};
    endfunction

    function automatic logic is_ctrl(input logic [VALUE_BITS-1:0] m);
        logic [VALUE_BITS-1:0] m1;
        m1 = m - VALUE_BITS'(1);
        return (m != '0) && m1[CTRL_BIT];
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, hits_reg};

    assign b         = s_tdata;
    assign is_digit  = b inside {[8'h30:8'h39]};
    assign letter_ok = target_letter_reg <= LETTER_MAX;
    assign lower_val = VALUE_BITS'(CH_LOWER_A + {3'b0, target_letter_reg});
    assign upper_val = VALUE_BITS'(CH_UPPER_A + {3'b0, target_letter_reg});

    always_comb begin
        byte_count_next = byte_count_reg;
        csiu_phase_next = csiu_phase_reg;
        csiu_code_next  = csiu_code_reg;
        csiu_mod_next   = csiu_mod_reg;
        mok_phase_next  = mok_phase_reg;
        mok_mod_next    = mok_mod_reg;
        mok_key_next    = mok_key_reg;
        overflow_next   = overflow_reg;
        hits_next       = 2'b00;

        // csi-u parser
        case (csiu_phase_reg)
            KP_PREFIX: begin
                if (byte_count_reg > 3'd1 ||
                    b != ((byte_count_reg == 3'd0) ? CH_ESC : CH_LBRACKET)) begin
                    csiu_phase_next = KP_FAIL;
                end else if (byte_count_reg == 3'd1) begin
                    csiu_phase_next = KP_CODE0;
                end
            end
            KP_CODE0, KP_CODE: begin
                if (is_digit) begin
                    if (!overflow_reg[0]) begin
                        {overflow_next[0], csiu_code_next} = accumulate(csiu_code_reg, b);
                    end
                    csiu_phase_next = KP_CODE;
                end else if (b == CH_SEMI && csiu_phase_reg == KP_CODE) begin
                    csiu_phase_next = KP_MOD0;
                end else begin
                    csiu_phase_next = KP_FAIL;
                end
            end
            KP_MOD0, KP_MOD: begin
                if (is_digit) begin
                    if (!overflow_reg[1]) begin
                        {overflow_next[1], csiu_mod_next} = accumulate(csiu_mod_reg, b);
                    end
                    csiu_phase_next = KP_MOD;
                end else if (b == CH_COLON && csiu_phase_reg == KP_MOD) begin
                    csiu_phase_next = KP_TAIL;
                end else begin
                    csiu_phase_next = KP_FAIL;
                end
            end
            KP_TAIL: csiu_phase_next = KP_TAIL;
            default: csiu_phase_next = KP_FAIL;
        endcase

        // modifyOtherKeys parser
        case (mok_phase_reg)
            MP_PREFIX: begin
                if (byte_count_reg >= MOK_PREFIX_LEN ||
                    b != mok_prefix_byte(byte_count_reg)) begin
                    mok_phase_next = MP_FAIL;
                end else if (byte_count_reg == MOK_PREFIX_LEN - 3'd1) begin
                    mok_phase_next = MP_MOD0;
                end
            end
            MP_MOD0, MP_MOD: begin
                if (is_digit) begin
                    if (!overflow_reg[2]) begin
                        {overflow_next[2], mok_mod_next} = accumulate(mok_mod_reg, b);
                    end
                    mok_phase_next = MP_MOD;
                end else if (b == CH_SEMI && mok_phase_reg == MP_MOD) begin
                    mok_phase_next = MP_KEY0;
                end else begin
                    mok_phase_next = MP_FAIL;
                end
            end
            MP_KEY0, MP_KEY: begin
                if (is_digit) begin
                    if (!overflow_reg[3]) begin
                        {overflow_next[3], mok_key_next} = accumulate(mok_key_reg, b);
                    end
                    mok_phase_next = MP_KEY;
                end else begin
                    mok_phase_next = MP_FAIL;
                end
            end
            default: mok_phase_next = MP_FAIL;
        endcase

        if (byte_count_reg < COUNT_MAX) begin
            byte_count_next = byte_count_reg + 3'd1;
        end

        // result on the last byte, from the state before it
        if (letter_ok && byte_count_reg == 3'd0 && b == {3'b0, target_letter_reg} + 8'd1) begin
            hits_next[0] = 1'b1;
        end
        if (letter_ok && b == CH_U &&
            (csiu_phase_reg == KP_MOD || csiu_phase_reg == KP_TAIL) &&
            overflow_reg[1:0] == 2'b00 &&
            (csiu_code_reg == lower_val || csiu_code_reg == upper_val) &&
            is_ctrl(csiu_mod_reg)) begin
            hits_next[0] = 1'b1;
        end
        if (b == CH_TILDE && mok_phase_reg == MP_KEY && overflow_reg[3:2] == 2'b00 &&
            is_ctrl(mok_mod_reg)) begin
            if (letter_ok && (mok_key_reg == lower_val || mok_key_reg == upper_val)) begin
                hits_next[0] = 1'b1;
            end
            if (mok_key_reg == VALUE_BITS'(ENTER_KEY)) begin
                hits_next[1] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_letter_reg <= '0;
            byte_count_reg    <= '0;
            csiu_phase_reg    <= KP_PREFIX;
            csiu_code_reg     <= '0;
            csiu_mod_reg      <= '0;
            mok_phase_reg     <= MP_PREFIX;
            mok_mod_reg       <= '0;
            mok_key_reg       <= '0;
            overflow_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                target_letter_reg <= cfg_wdata;
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_accept) begin
                if (s_tlast) begin
                    byte_count_reg <= '0;
                    csiu_phase_reg <= KP_PREFIX;
                    csiu_code_reg  <= '0;
                    csiu_mod_reg   <= '0;
                    mok_phase_reg  <= MP_PREFIX;
                    mok_mod_reg    <= '0;
                    mok_key_reg    <= '0;
                    overflow_reg   <= '0;
                    m_tvalid_reg   <= 1'b1;
                end else begin
                    byte_count_reg <= byte_count_next;
                    csiu_phase_reg <= csiu_phase_next;
                    csiu_code_reg  <= csiu_code_next;
                    csiu_mod_reg   <= csiu_mod_next;
                    mok_phase_reg  <= mok_phase_next;
                    mok_mod_reg    <= mok_mod_next;
                    mok_key_reg    <= mok_key_next;
                    overflow_reg   <= overflow_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            hits_reg <= hits_next;
        end
    end

    // enter key code never equals a letter code
    a_hits_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(hits_reg[0] && hits_reg[1]))
        else $error("letter and enter hit together");

    a_event_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (byte_count_reg == 3'd0 && csiu_phase_reg == KP_PREFIX &&
                                   mok_phase_reg == MP_PREFIX && overflow_reg == 4'b0000))
        else $error("event state not cleared after last byte");

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg && s_accept && !s_tlast) |=> !m_tvalid_reg)
        else $error("result without last byte");

    a_overflow_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg[0] |-> csiu_code_reg == VALUE_MAX)
        else $error("overflowed token not saturated");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for ctrl_key_escape_sequence_matcher. Streams terminal key events
// byte by byte, predicts the Ctrl+letter and Ctrl+Enter verdict of each event
// and checks every request on the master side against it, under random
// stalls on both sides and several target letters.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cksm_pkg::*;

    localparam int          VALUE_BITS = 31;
    localparam logic [63:0] VALUE_MAX  = (64'd1 << VALUE_BITS) - 64'd1;
    localparam int          LIMIT      = 300000;
    localparam int          DRAIN_WAIT = 4;
    localparam int          PHASE_BYTES = 160;

    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [39:0] MOK_LEAD = {CH_SEMI, CH_SEVEN, CH_TWO, CH_LBRACKET, CH_ESC};
    localparam logic [19:0] LETTER_EDGES = {5'd31, 5'd26, 5'd25, 5'd0};

    localparam int OVF_CSI_CODE = 0;
    localparam int OVF_CSI_MOD  = 1;
    localparam int OVF_MOK_MOD  = 2;
    localparam int OVF_MOK_KEY  = 3;

    typedef struct packed {
        logic letter_hit;
        logic enter_hit;
    } key_verdict_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wen = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    ctrl_key_escape_sequence_matcher #(.VALUE_BITS(VALUE_BITS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [4:0]            letter_reg = '0;
    logic [2:0]            kbd_count;
    csiu_phase_t           csi_state;
    logic [VALUE_BITS-1:0] csi_code;
    logic [VALUE_BITS-1:0] csi_mod;
    mok_phase_t            mok_state;
    logic [VALUE_BITS-1:0] mok_mod;
    logic [VALUE_BITS-1:0] mok_key;
    logic [3:0]            tok_ovf;

    key_verdict_t verdict_q[$];
    logic [7:0]   ev_q[$];

    int send_idle = 0;
    int recv_idle = 0;
    int cycle_count = 0;
    int n_errors = 0;
    int n_bytes = 0;
    int n_events = 0;
    int n_checked = 0;
    int n_letter_hits = 0;
    int n_enter_hits = 0;
    int n_settings = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("ctrl_key_escape_sequence_matcher: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    task automatic clear_key_event();
        kbd_count = '0;
        csi_state = KP_PREFIX;
        csi_code  = '0;
        csi_mod   = '0;
        mok_state = MP_PREFIX;
        mok_mod   = '0;
        mok_key   = '0;
        tok_ovf   = '0;
    endtask

    function automatic logic [VALUE_BITS-1:0] shift_in_digit(
        input logic [VALUE_BITS-1:0] acc, input int ovf_bit, input logic [7:0] b);
        logic [63:0] wide;
        if (tok_ovf[ovf_bit])
            return acc;
        wide = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
        if (wide > VALUE_MAX) begin
            tok_ovf[ovf_bit] = 1'b1;
            return VALUE_MAX[VALUE_BITS-1:0];
        end
        return wide[VALUE_BITS-1:0];
    endfunction

    function automatic logic mod_is_ctrl(input logic [VALUE_BITS-1:0] m);
        logic [VALUE_BITS-1:0] m1;
        m1 = m - VALUE_BITS'(1);
        return (m != '0) && m1[CTRL_BIT];
    endfunction

    task automatic predict_key_byte(input logic [7:0] b, input logic l);
        logic         d;
        logic         letter_ok;
        logic [7:0]   lower;
        logic [7:0]   upper;
        key_verdict_t v;
        d = (b >= CH_ZERO) && (b <= CH_NINE);
        if (!l) begin
            case (csi_state)
                KP_PREFIX: begin
                    if (kbd_count > 3'd1 || b != (kbd_count == 3'd0 ? CH_ESC : CH_LBRACKET))
                        csi_state = KP_FAIL;
                    else if (kbd_count == 3'd1)
                        csi_state = KP_CODE0;
                end
                KP_CODE0, KP_CODE: begin
                    if (d) begin
                        csi_code  = shift_in_digit(csi_code, OVF_CSI_CODE, b);
                        csi_state = KP_CODE;
                    end else if (b == CH_SEMI && csi_state == KP_CODE) begin
                        csi_state = KP_MOD0;
                    end else begin
                        csi_state = KP_FAIL;
                    end
                end
                KP_MOD0, KP_MOD: begin
                    if (d) begin
                        csi_mod   = shift_in_digit(csi_mod, OVF_CSI_MOD, b);
                        csi_state = KP_MOD;
                    end else if (b == CH_COLON && csi_state == KP_MOD) begin
                        csi_state = KP_TAIL;
                    end else begin
                        csi_state = KP_FAIL;
                    end
                end
                KP_TAIL: ;
                default: csi_state = KP_FAIL;
            endcase
            case (mok_state)
                MP_PREFIX: begin
                    if (kbd_count >= MOK_PREFIX_LEN || b != MOK_LEAD[kbd_count*8 +: 8])
                        mok_state = MP_FAIL;
                    else if (kbd_count == MOK_PREFIX_LEN - 3'd1)
                        mok_state = MP_MOD0;
                end
                MP_MOD0, MP_MOD: begin
                    if (d) begin
                        mok_mod   = shift_in_digit(mok_mod, OVF_MOK_MOD, b);
                        mok_state = MP_MOD;
                    end else if (b == CH_SEMI && mok_state == MP_MOD) begin
                        mok_state = MP_KEY0;
                    end else begin
                        mok_state = MP_FAIL;
                    end
                end
                MP_KEY0, MP_KEY: begin
                    if (d) begin
                        mok_key   = shift_in_digit(mok_key, OVF_MOK_KEY, b);
                        mok_state = MP_KEY;
                    end else begin
                        mok_state = MP_FAIL;
                    end
                end
                default: mok_state = MP_FAIL;
            endcase
            if (kbd_count < COUNT_MAX)
                kbd_count = kbd_count + 3'd1;
        end else begin
            letter_ok = (letter_reg <= LETTER_MAX);
            lower = CH_LOWER_A + {3'b000, letter_reg};
            upper = CH_UPPER_A + {3'b000, letter_reg};
            v = '0;
            if (letter_ok && kbd_count == 3'd0 && b == {3'b000, letter_reg} + 8'd1)
                v.letter_hit = 1'b1;
            if (letter_ok && b == CH_U && (csi_state == KP_MOD || csi_state == KP_TAIL)
                && !tok_ovf[OVF_CSI_CODE] && !tok_ovf[OVF_CSI_MOD]
                && (csi_code == lower || csi_code == upper) && mod_is_ctrl(csi_mod))
                v.letter_hit = 1'b1;
            if (b == CH_TILDE && mok_state == MP_KEY && !tok_ovf[OVF_MOK_MOD]
                && !tok_ovf[OVF_MOK_KEY] && mod_is_ctrl(mok_mod)) begin
                if (letter_ok && (mok_key == lower || mok_key == upper))
                    v.letter_hit = 1'b1;
                if (mok_key == ENTER_KEY)
                    v.enter_hit = 1'b1;
            end
            verdict_q.push_back(v);
            n_letter_hits += int'(v.letter_hit);
            n_enter_hits  += int'(v.enter_hit);
            clear_key_event();
        end
    endtask

    initial begin : result_monitor
        logic         sampled;
        logic [7:0]   got;
        key_verdict_t want;
        forever begin
            @(posedge aclk);
            sampled = aresetn && m_tvalid && m_tready;
            got = m_tdata;
            @(negedge aclk);
            if (sampled) begin
                if (verdict_q.size() == 0) begin
                    $error("request with no verdict pending, tdata %h", got);
                    n_errors++;
                end else begin
                    want = verdict_q.pop_front();
                    n_checked++;
                    if (got[0] !== want.letter_hit) begin
                        $error("ctrl_letter_hit expected %0b actual %0b", want.letter_hit, got[0]);
                        n_errors++;
                    end
                    if (got[1] !== want.enter_hit) begin
                        $error("ctrl_enter_hit expected %0b actual %0b", want.enter_hit, got[1]);
                        n_errors++;
                    end
                    if (got[7:2] !== 6'd0) begin
                        $error("pad expected 0 actual %h", got[7:2]);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_key_byte(b, l);
        n_bytes++;
    endtask

    task automatic send_event();
        n_events++;
        foreach (ev_q[i])
            send_byte(ev_q[i], i == ev_q.size() - 1);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            ev_q.push_back(s[i]);
    endtask

    task automatic send_lone(input logic [7:0] b);
        ev_q.delete();
        ev_q.push_back(b);
        send_event();
    endtask

    task automatic send_escape(input string s);
        ev_q.delete();
        ev_q.push_back(CH_ESC);
        add_text(s);
        send_event();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_letter(input logic [4:0] v);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        letter_reg = v;
        n_settings++;
    endtask

    function automatic string key_token();
        longint unsigned v;
        case ($urandom_range(11))
            0, 1, 2: v = CH_LOWER_A + letter_reg;
            3, 4:    v = CH_UPPER_A + letter_reg;
            5:       v = ENTER_KEY;
            6:       v = $urandom_range(0, 300);
            7:       v = VALUE_MAX;
            8:       v = VALUE_MAX + 1 + $urandom_range(0, 200);
            9:       v = {$urandom, $urandom};
            10:      return {"00", $sformatf("%0d", CH_LOWER_A + letter_reg)};
            default: v = $urandom_range(0, 9);
        endcase
        return $sformatf("%0d", v);
    endfunction

    function automatic string mod_token();
        longint unsigned v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(1, 16);
            6:       v = 0;
            7:       v = VALUE_MAX;
            8:       v = VALUE_MAX + 1 + $urandom_range(0, 20);
            default: return {"000", $sformatf("%0d", $urandom_range(1, 16))};
        endcase
        return $sformatf("%0d", v);
    endfunction

    task automatic build_csiu();
        ev_q.delete();
        ev_q.push_back(CH_ESC);
        add_text({"[", key_token(), ";", mod_token()});
        if ($urandom_range(3) == 0) begin
            ev_q.push_back(CH_COLON);
            repeat ($urandom_range(0, 3)) ev_q.push_back(8'($urandom_range(255)));
        end
        ev_q.push_back(CH_U);
    endtask

    task automatic build_mok();
        ev_q.delete();
        ev_q.push_back(CH_ESC);
        add_text({"[27;", mod_token(), ";", key_token()});
        ev_q.push_back(CH_TILDE);
    endtask

    task automatic break_event();
        int at;
        at = $urandom_range(ev_q.size() - 1);
        case ($urandom_range(3))
            0: ev_q[at] = 8'($urandom_range(255));
            1: if (ev_q.size() > 1) ev_q.delete(at);
            2: ev_q.insert(at, CH_MINUS);
            default: while (ev_q.size() > at + 1) void'(ev_q.pop_back());
        endcase
    endtask

    task automatic test_reset_letter();
        send_lone(8'h01);
        drain();
    endtask

    task automatic test_lone_bytes();
        write_letter(LETTER_MAX);
        send_lone(8'h1A);
        send_lone(8'hFF);
        drain();
    endtask

    task automatic test_csiu();
        send_escape("[90;5:9-u");
        send_escape("[122;-5u");
        send_escape("[u");
        drain();
    endtask

    task automatic test_mok();
        send_escape("[27;5;13~");
        send_escape("[27;5;4294967309~");
        drain();
    endtask

    task automatic test_letter_range();
        write_letter(5'd31);
        send_lone(8'h20);
        send_escape("[27;5;13~");
        write_letter(5'd26);
        send_lone(CH_ESC);
        drain();
    endtask

    task automatic test_random_events();
        int phase_bytes;
        int sel;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 19 : (phase == 1) ? 70 : 0;
            recv_idle = (phase == 0) ? 70 : (phase == 1) ? 19 : 0;
            for (int k = 0; k < 4; k++) begin
                if (k < 2)
                    write_letter(LETTER_EDGES[((2 * phase + k) % 4) * 5 +: 5]);
                else if ($urandom_range(9) == 0)
                    write_letter(5'($urandom_range(26, 31)));
                else
                    write_letter(5'($urandom_range(0, 25)));
                phase_bytes = n_bytes;
                while (n_bytes - phase_bytes < PHASE_BYTES) begin
                    sel = $urandom_range(99);
                    if (sel < 10) begin
                        ev_q.delete();
                        ev_q.push_back($urandom_range(3) == 0 ?
                                       8'($urandom_range(255)) : 8'($urandom_range(32)));
                    end else if (sel < 40) begin
                        build_csiu();
                    end else if (sel < 70) begin
                        build_mok();
                    end else if (sel < 85) begin
                        if (sel[0]) build_csiu();
                        else build_mok();
                        break_event();
                    end else begin
                        ev_q.delete();
                        repeat ($urandom_range(1, 9)) ev_q.push_back(8'($urandom_range(255)));
                    end
                    send_event();
                end
            end
        end
        drain();
    endtask

    initial begin
        clear_key_event();
        send_idle = 19;
        recv_idle = 70;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_letter();
        test_lone_bytes();
        test_csiu();
        test_mok();
        test_letter_range();
        test_random_events();
        $display("covered %0d bytes in %0d key events over %0d letter settings",
                 n_bytes, n_events, n_settings);
        $display("checked %0d verdicts, %0d ctrl+letter and %0d ctrl+enter hits among them",
                 n_checked, n_letter_hits, n_enter_hits);
        if (n_errors == 0)
            $display("ctrl_key_escape_sequence_matcher: match");
        else
            $display("ctrl_key_escape_sequence_matcher: mismatch");
        $finish;
    end

endmodule
